[sv/mde_pkg.sv]
// Package: shared word types, opcode and function codes, and control structs.
`default_nettype none
package mde_pkg;

    typedef struct packed {
        logic [31:0] instr;
        logic [31:0] pc;
        logic [31:0] rs_value;
        logic [31:0] rt_value;
    } in_word_t;

    typedef struct packed {
        logic [31:0] next_pc;
        logic [4:0]  dest_reg;
        logic        reg_write;
        logic [31:0] write_value;
        logic        mem_read;
        logic        mem_write;
        logic [31:0] mem_address;
        logic [31:0] store_data;
        logic [3:0]  byte_enables;
        logic [2:0]  load_kind;
        logic        halt;
        logic        unknown_op;
    } out_word_t;

    typedef struct packed {
        logic accept;
        logic step;
        logic finish;
    } mde_cmd_t;

    typedef struct packed {
        logic long_op;
    } mde_status_t;

    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_REGIMM  = 6'h01;
    localparam logic [5:0] OP_J       = 6'h02;
    localparam logic [5:0] OP_JAL     = 6'h03;
    localparam logic [5:0] OP_BEQ     = 6'h04;
    localparam logic [5:0] OP_BNE     = 6'h05;
    localparam logic [5:0] OP_BLEZ    = 6'h06;
    localparam logic [5:0] OP_BGTZ    = 6'h07;
    localparam logic [5:0] OP_ADDI    = 6'h08;
    localparam logic [5:0] OP_ADDIU   = 6'h09;
    localparam logic [5:0] OP_SLTI    = 6'h0A;
    localparam logic [5:0] OP_SLTIU   = 6'h0B;
    localparam logic [5:0] OP_ANDI    = 6'h0C;
    localparam logic [5:0] OP_ORI     = 6'h0D;
    localparam logic [5:0] OP_XORI    = 6'h0E;
    localparam logic [5:0] OP_LUI     = 6'h0F;
    localparam logic [5:0] OP_LB      = 6'h20;
    localparam logic [5:0] OP_LH      = 6'h21;
    localparam logic [5:0] OP_LW      = 6'h23;
    localparam logic [5:0] OP_LBU     = 6'h24;
    localparam logic [5:0] OP_LHU     = 6'h25;
    localparam logic [5:0] OP_SB      = 6'h28;
    localparam logic [5:0] OP_SH      = 6'h29;
    localparam logic [5:0] OP_SW      = 6'h2B;

    localparam logic [5:0] FN_SLL     = 6'h00;
    localparam logic [5:0] FN_SRL     = 6'h02;
    localparam logic [5:0] FN_SRA     = 6'h03;
    localparam logic [5:0] FN_SLLV    = 6'h04;
    localparam logic [5:0] FN_SRLV    = 6'h06;
    localparam logic [5:0] FN_SRAV    = 6'h07;
    localparam logic [5:0] FN_JR      = 6'h08;
    localparam logic [5:0] FN_JALR    = 6'h09;
    localparam logic [5:0] FN_SYSCALL = 6'h0C;
    localparam logic [5:0] FN_MFHI    = 6'h10;
    localparam logic [5:0] FN_MTHI    = 6'h11;
    localparam logic [5:0] FN_MFLO    = 6'h12;
    localparam logic [5:0] FN_MTLO    = 6'h13;
    localparam logic [5:0] FN_MULT    = 6'h18;
    localparam logic [5:0] FN_MULTU   = 6'h19;
    localparam logic [5:0] FN_DIV     = 6'h1A;
    localparam logic [5:0] FN_DIVU    = 6'h1B;
    localparam logic [5:0] FN_ADD     = 6'h20;
    localparam logic [5:0] FN_ADDU    = 6'h21;
    localparam logic [5:0] FN_SUB     = 6'h22;
    localparam logic [5:0] FN_SUBU    = 6'h23;
    localparam logic [5:0] FN_AND     = 6'h24;
    localparam logic [5:0] FN_OR      = 6'h25;
    localparam logic [5:0] FN_XOR     = 6'h26;
    localparam logic [5:0] FN_NOR     = 6'h27;
    localparam logic [5:0] FN_SLT     = 6'h2A;
    localparam logic [5:0] FN_SLTU    = 6'h2B;

    localparam logic [4:0] RT_BLTZ    = 5'h00;
    localparam logic [4:0] RT_BGEZ    = 5'h01;
    localparam logic [4:0] RT_BLTZAL  = 5'h10;
    localparam logic [4:0] RT_BGEZAL  = 5'h11;

    localparam logic [2:0] LK_WORD    = 3'd0;
    localparam logic [2:0] LK_SBYTE   = 3'd1;
    localparam logic [2:0] LK_SHALF   = 3'd2;
    localparam logic [2:0] LK_UBYTE   = 3'd3;
    localparam logic [2:0] LK_UHALF   = 3'd4;

    localparam logic [4:0] LINK_REG   = 5'd31;
    localparam int         ITER_STEPS = 32;

endpackage
`default_nettype wire

[sv/mde_ctrl.sv]
// Controller: accept handshake, output valid, and multiply/divide sequencing.
`default_nettype none
module mde_ctrl
    import mde_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        src_valid,
    output logic             src_stall,
    output logic             dst_valid,
    input  wire logic        dst_stall,
    input  wire mde_status_t status,
    output mde_cmd_t         cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_ITER = 2'd1;
    localparam logic [1:0] S_FIX  = 2'd2;
    localparam logic [4:0] LAST_STEP = 5'(ITER_STEPS - 1);

    logic [1:0] state_reg, state_next;
    logic [4:0] count_reg, count_next;
    logic       valid_reg, valid_next;

    assign src_stall  = (state_reg != S_IDLE) || (valid_reg && dst_stall);
    assign dst_valid  = valid_reg;
    assign cmd.accept = src_valid && !src_stall;
    assign cmd.step   = (state_reg == S_ITER);
    assign cmd.finish = (state_reg == S_FIX);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        valid_next = valid_reg && dst_stall;
        if (cmd.accept)
        begin
            valid_next = 1'b1;
        end
        case (state_reg)
            S_IDLE:
            begin
                count_next = '0;
                if (cmd.accept && status.long_op)
                begin
                    state_next = S_ITER;
                end
            end
            S_ITER:
            begin
                count_next = count_reg + 5'd1;
                if (count_reg == LAST_STEP)
                begin
                    state_next = S_FIX;
                end
            end
            S_FIX:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            valid_reg <= valid_next;
        end
    end

    a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> src_stall)
        else $error("input taken while unit busy");
    a_long_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept && status.long_op) |=> (state_reg == S_ITER))
        else $error("long op did not start");
    a_iter_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ITER && count_reg == LAST_STEP) |=> (state_reg == S_FIX))
        else $error("iteration count wrong");
    a_fix_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIX) |=> (state_reg == S_IDLE))
        else $error("fix state did not return");
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && dst_stall) |=> valid_reg)
        else $error("stalled word dropped");

endmodule
`default_nettype wire

[sv/mde_datapath.sv]
// Datapath: decode and execute, HI/LO, iterative multiply/divide, output register.
`default_nettype none
module mde_datapath
    import mde_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire in_word_t src_data,
    input  wire mde_cmd_t cmd,
    output mde_status_t   status,
    output out_word_t     dst_data
);

    logic [5:0]  op, fn;
    logic [4:0]  rtf, rdf, sa;
    logic [15:0] imm;
    logic [31:0] rs, rt, simm, seq, btgt, addr, jtgt;
    out_word_t   res;
    logic        hi_wr, lo_wr, is_mul, is_div, sgn;
    logic [31:0] hi_val, lo_val;

    logic [31:0] hi_reg, lo_reg;
    out_word_t   out_reg;
    logic [31:0] acc_hi_reg, acc_lo_reg, b_reg;
    logic        mul_reg, qneg_reg, rneg_reg;

    logic [32:0] mul_sum, div_t, div_diff;
    logic [63:0] prod, prod_neg;
    logic [31:0] fin_hi, fin_lo;

    always_comb
    begin
        op   = src_data.instr[31:26];
        fn   = src_data.instr[5:0];
        rtf  = src_data.instr[20:16];
        rdf  = src_data.instr[15:11];
        sa   = src_data.instr[10:6];
        imm  = src_data.instr[15:0];
        rs   = src_data.rs_value;
        rt   = src_data.rt_value;
        simm = {{16{imm[15]}}, imm};
        seq  = src_data.pc + 32'd4;
        btgt = seq + {simm[29:0], 2'b00};
        addr = rs + simm;
        jtgt = {src_data.pc[31:28], src_data.instr[25:0], 2'b00};

        res = '0;
        res.next_pc = seq;
        hi_wr  = 1'b0;
        lo_wr  = 1'b0;
        hi_val = rs;
        lo_val = rs;
        is_mul = 1'b0;
        is_div = 1'b0;
        sgn    = 1'b0;

        case (op)
            OP_SPECIAL:
            begin
                res.dest_reg  = rdf;
                res.reg_write = 1'b1;
                case (fn)
                    FN_SLL:  res.write_value = rt << sa;
                    FN_SRL:  res.write_value = rt >> sa;
                    FN_SRA:  res.write_value = 32'($signed(rt) >>> sa);
                    FN_SLLV: res.write_value = rt << rs[4:0];
                    FN_SRLV: res.write_value = rt >> rs[4:0];
                    FN_SRAV: res.write_value = 32'($signed(rt) >>> rs[4:0]);
                    FN_JR:
                    begin
                        res.reg_write = 1'b0;
                        res.next_pc   = rs;
                    end
                    FN_JALR:
                    begin
                        res.write_value = seq;
                        res.next_pc     = rs;
                    end
                    FN_SYSCALL:
                    begin
                        res.reg_write = 1'b0;
                        res.halt      = 1'b1;
                    end
                    FN_MFHI: res.write_value = hi_reg;
                    FN_MFLO: res.write_value = lo_reg;
                    FN_MTHI:
                    begin
                        res.reg_write = 1'b0;
                        hi_wr = 1'b1;
                    end
                    FN_MTLO:
                    begin
                        res.reg_write = 1'b0;
                        lo_wr = 1'b1;
                    end
                    FN_MULT, FN_MULTU:
                    begin
                        res.reg_write = 1'b0;
                        is_mul = 1'b1;
                        sgn    = (fn == FN_MULT);
                    end
                    FN_DIV, FN_DIVU:
                    begin
                        res.reg_write = 1'b0;
                        sgn = (fn == FN_DIV);
                        if (rt == 32'd0)
                        begin
                            hi_wr  = 1'b1;
                            lo_wr  = 1'b1;
                            lo_val = 32'hFFFF_FFFF;
                        end
                        else
                        begin
                            is_div = 1'b1;
                        end
                    end
                    FN_ADD, FN_ADDU: res.write_value = rs + rt;
                    FN_SUB, FN_SUBU: res.write_value = rs - rt;
                    FN_AND:  res.write_value = rs & rt;
                    FN_OR:   res.write_value = rs | rt;
                    FN_XOR:  res.write_value = rs ^ rt;
                    FN_NOR:  res.write_value = ~(rs | rt);
                    FN_SLT:  res.write_value = {31'd0, $signed(rs) < $signed(rt)};
                    FN_SLTU: res.write_value = {31'd0, rs < rt};
                    default:
                    begin
                        res.reg_write  = 1'b0;
                        res.unknown_op = 1'b1;
                    end
                endcase
            end
            OP_REGIMM:
            begin
                case (rtf)
                    RT_BLTZ, RT_BLTZAL:
                    begin
                        if (rs[31])
                        begin
                            res.next_pc = btgt;
                        end
                    end
                    RT_BGEZ, RT_BGEZAL:
                    begin
                        if (!rs[31])
                        begin
                            res.next_pc = btgt;
                        end
                    end
                    default:
                    begin
                        res.unknown_op = 1'b1;
                    end
                endcase
                if (!res.unknown_op && rtf[4])
                begin
                    res.reg_write   = 1'b1;
                    res.dest_reg    = LINK_REG;
                    res.write_value = seq;
                end
            end
            OP_J:
            begin
                res.next_pc = jtgt;
            end
            OP_JAL:
            begin
                res.next_pc     = jtgt;
                res.reg_write   = 1'b1;
                res.dest_reg    = LINK_REG;
                res.write_value = seq;
            end
            OP_BEQ:  if (rs == rt) res.next_pc = btgt;
            OP_BNE:  if (rs != rt) res.next_pc = btgt;
            OP_BLEZ: if (rs[31] || rs == 32'd0) res.next_pc = btgt;
            OP_BGTZ: if (!rs[31] && rs != 32'd0) res.next_pc = btgt;
            OP_ADDI, OP_ADDIU, OP_SLTI, OP_SLTIU, OP_ANDI, OP_ORI, OP_XORI, OP_LUI:
            begin
                res.reg_write = 1'b1;
                res.dest_reg  = rtf;
                case (op)
                    OP_SLTI:  res.write_value = {31'd0, $signed(rs) < $signed(simm)};
                    OP_SLTIU: res.write_value = {31'd0, rs < simm};
                    OP_ANDI:  res.write_value = rs & {16'd0, imm};
                    OP_ORI:   res.write_value = rs | {16'd0, imm};
                    OP_XORI:  res.write_value = rs ^ {16'd0, imm};
                    OP_LUI:   res.write_value = {imm, 16'd0};
                    default:  res.write_value = addr;
                endcase
            end
            OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU:
            begin
                res.reg_write   = 1'b1;
                res.dest_reg    = rtf;
                res.mem_read    = 1'b1;
                res.mem_address = addr;
                case (op)
                    OP_LB:   res.load_kind = LK_SBYTE;
                    OP_LH:   res.load_kind = LK_SHALF;
                    OP_LBU:  res.load_kind = LK_UBYTE;
                    OP_LHU:  res.load_kind = LK_UHALF;
                    default: res.load_kind = LK_WORD;
                endcase
            end
            OP_SB:
            begin
                res.mem_write    = 1'b1;
                res.mem_address  = addr;
                res.store_data   = {24'd0, rt[7:0]} << {addr[1:0], 3'b000};
                res.byte_enables = 4'b0001 << addr[1:0];
            end
            OP_SH:
            begin
                res.mem_write    = 1'b1;
                res.mem_address  = addr;
                res.store_data   = addr[1] ? {rt[15:0], 16'd0} : {16'd0, rt[15:0]};
                res.byte_enables = addr[1] ? 4'b1100 : 4'b0011;
            end
            OP_SW:
            begin
                res.mem_write    = 1'b1;
                res.mem_address  = addr;
                res.store_data   = rt;
                res.byte_enables = 4'b1111;
            end
            default:
            begin
                res.unknown_op = 1'b1;
            end
        endcase

        if (!res.reg_write)
        begin
            res.dest_reg    = '0;
            res.write_value = '0;
        end
    end

    assign status.long_op = is_mul || is_div;
    assign dst_data       = out_reg;

    always_comb
    begin
        mul_sum  = {1'b0, acc_hi_reg} + (acc_lo_reg[0] ? {1'b0, b_reg} : 33'd0);
        div_t    = {acc_hi_reg, acc_lo_reg[31]};
        div_diff = div_t - {1'b0, b_reg};
        prod     = {acc_hi_reg, acc_lo_reg};
        prod_neg = 64'd0 - prod;
        if (mul_reg)
        begin
            fin_hi = qneg_reg ? prod_neg[63:32] : prod[63:32];
            fin_lo = qneg_reg ? prod_neg[31:0] : prod[31:0];
        end
        else
        begin
            fin_hi = rneg_reg ? 32'd0 - acc_hi_reg : acc_hi_reg;
            fin_lo = qneg_reg ? 32'd0 - acc_lo_reg : acc_lo_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hi_reg <= '0;
            lo_reg <= '0;
        end
        else if (cmd.finish)
        begin
            hi_reg <= fin_hi;
            lo_reg <= fin_lo;
        end
        else if (cmd.accept)
        begin
            if (hi_wr)
            begin
                hi_reg <= hi_val;
            end
            if (lo_wr)
            begin
                lo_reg <= lo_val;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            out_reg    <= res;
            mul_reg    <= is_mul;
            qneg_reg   <= sgn && (rs[31] ^ rt[31]);
            rneg_reg   <= sgn && rs[31];
            acc_hi_reg <= '0;
            acc_lo_reg <= (sgn && rs[31]) ? 32'd0 - rs : rs;
            b_reg      <= (sgn && rt[31]) ? 32'd0 - rt : rt;
        end
        else if (cmd.step)
        begin
            if (mul_reg)
            begin
                acc_hi_reg <= mul_sum[32:1];
                acc_lo_reg <= {mul_sum[0], acc_lo_reg[31:1]};
            end
            else if (!div_diff[32])
            begin
                acc_hi_reg <= div_diff[31:0];
                acc_lo_reg <= {acc_lo_reg[30:0], 1'b1};
            end
            else
            begin
                acc_hi_reg <= div_t[31:0];
                acc_lo_reg <= {acc_lo_reg[30:0], 1'b0};
            end
        end
    end

endmodule
`default_nettype wire

[sv/mips_decode_execute_unit.sv]
// Top level: MIPS32 decode and execute unit with HI/LO and multiply/divide.
// Input channel src_valid/src_stall/src_data carries one instruction word
// (instr, pc, rs_value, rt_value); output channel dst_valid/dst_stall/dst_data
// carries one result word per instruction (next PC, register write, memory
// request, halt and unknown flags).
// Each result word appears in the cycle after its instruction is taken.
// Throughput: one instruction per cycle while no word waits on dst_stall, for
// everything except MULT, MULTU, DIV and DIVU with a nonzero divisor; those
// occupy the unit for a load cycle, 32 shift-add or restoring-divide steps of
// the shared iterative unit and a sign-fix cycle, with src_stall high through
// the steps and sign-fix. Their result issues at once; HI/LO update at sign-fix.
// The output register lets a new instruction be taken in the same cycle the
// previous result word leaves; while dst_stall is high and a word waits,
// src_stall is high and the waiting word holds.
// Reset clears HI, LO, the controller state and the output valid.
`default_nettype none
module mips_decode_execute_unit
    import mde_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     src_valid,
    output logic          src_stall,
    input  wire in_word_t src_data,
    output logic          dst_valid,
    input  wire logic     dst_stall,
    output out_word_t     dst_data
);

    mde_cmd_t    cmd;
    mde_status_t status;

    mde_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .status    (status),
        .cmd       (cmd)
    );

    mde_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .src_data (src_data),
        .cmd      (cmd),
        .status   (status),
        .dst_data (dst_data)
    );

endmodule
`default_nettype wire

[bench/mips_decode_execute_unit_tb.sv]
// Testbench: directed table and random instruction words checked against a predictor.
`default_nettype none
module mips_decode_execute_unit_tb;
    import mde_pkg::*;

    logic      clk;
    logic      rst_n;
    logic      src_valid;
    logic      src_stall;
    in_word_t  src_data;
    logic      dst_valid;
    logic      dst_stall;
    out_word_t dst_data;

    mips_decode_execute_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .src_valid(src_valid),
        .src_stall(src_stall),
        .src_data (src_data),
        .dst_valid(dst_valid),
        .dst_stall(dst_stall),
        .dst_data (dst_data)
    );

    typedef struct {
        in_word_t  word;
        logic      known;
        out_word_t result;
    } row_t;

    logic [31:0] hi_q;
    logic [31:0] lo_q;
    out_word_t   pending_q[$];
    int          errors;
    int          idle_cycles;
    bit          quiet;
    int          src_gap;
    int          dst_hold;

    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [31:0] shift_right_arith(logic [31:0] x, logic [4:0] s);
        return $unsigned($signed(x) >>> s);
    endfunction

    function automatic out_word_t execute(in_word_t w);
        out_word_t   r;
        logic [5:0]  op;
        logic [5:0]  fn;
        logic [4:0]  rtf;
        logic [4:0]  sa;
        logic [31:0] rs;
        logic [31:0] rt;
        logic [31:0] imm;
        logic [31:0] simm;
        logic [31:0] seq;
        logic [31:0] btgt;
        logic [31:0] jtgt;
        logic [63:0] prod;
        logic [31:0] ua;
        logic [31:0] ub;
        logic [31:0] uq;
        logic [31:0] ur;
        logic [1:0]  lane;
        r    = '0;
        op   = w.instr[31:26];
        fn   = w.instr[5:0];
        rtf  = w.instr[20:16];
        sa   = w.instr[10:6];
        rs   = w.rs_value;
        rt   = w.rt_value;
        imm  = {16'h0, w.instr[15:0]};
        simm = {{16{w.instr[15]}}, w.instr[15:0]};
        seq  = w.pc + 32'd4;
        btgt = seq + (simm << 2);
        jtgt = {w.pc[31:28], w.instr[25:0], 2'b00};
        r.next_pc = seq;
        case (op)
            OP_SPECIAL:
            begin
                r.dest_reg  = w.instr[15:11];
                r.reg_write = 1'b1;
                case (fn)
                    FN_SLL:  r.write_value = rt << sa;
                    FN_SRL:  r.write_value = rt >> sa;
                    FN_SRA:  r.write_value = shift_right_arith(rt, sa);
                    FN_SLLV: r.write_value = rt << rs[4:0];
                    FN_SRLV: r.write_value = rt >> rs[4:0];
                    FN_SRAV: r.write_value = shift_right_arith(rt, rs[4:0]);
                    FN_JR:
                    begin
                        r.reg_write = 1'b0;
                        r.next_pc   = rs;
                    end
                    FN_JALR:
                    begin
                        r.write_value = seq;
                        r.next_pc     = rs;
                    end
                    FN_SYSCALL:
                    begin
                        r.reg_write = 1'b0;
                        r.halt      = 1'b1;
                    end
                    FN_MFHI: r.write_value = hi_q;
                    FN_MFLO: r.write_value = lo_q;
                    FN_MTHI:
                    begin
                        r.reg_write = 1'b0;
                        hi_q        = rs;
                    end
                    FN_MTLO:
                    begin
                        r.reg_write = 1'b0;
                        lo_q        = rs;
                    end
                    FN_MULT, FN_MULTU:
                    begin
                        r.reg_write = 1'b0;
                        if (fn == FN_MULT)
                            prod = $unsigned($signed({{32{rs[31]}}, rs})
                                             * $signed({{32{rt[31]}}, rt}));
                        else
                            prod = {32'h0, rs} * {32'h0, rt};
                        hi_q = prod[63:32];
                        lo_q = prod[31:0];
                    end
                    FN_DIV, FN_DIVU:
                    begin
                        r.reg_write = 1'b0;
                        if (rt == 32'h0)
                        begin
                            lo_q = 32'hFFFF_FFFF;
                            hi_q = rs;
                        end
                        else if (fn == FN_DIVU)
                        begin
                            lo_q = rs / rt;
                            hi_q = rs % rt;
                        end
                        else
                        begin
                            ua   = rs[31] ? -rs : rs;
                            ub   = rt[31] ? -rt : rt;
                            uq   = ua / ub;
                            ur   = ua % ub;
                            lo_q = (rs[31] != rt[31]) ? -uq : uq;
                            hi_q = rs[31] ? -ur : ur;
                        end
                    end
                    FN_ADD, FN_ADDU: r.write_value = rs + rt;
                    FN_SUB, FN_SUBU: r.write_value = rs - rt;
                    FN_AND:  r.write_value = rs & rt;
                    FN_OR:   r.write_value = rs | rt;
                    FN_XOR:  r.write_value = rs ^ rt;
                    FN_NOR:  r.write_value = ~(rs | rt);
                    FN_SLT:  r.write_value = {31'h0, $signed(rs) < $signed(rt)};
                    FN_SLTU: r.write_value = {31'h0, rs < rt};
                    default:
                    begin
                        r.reg_write  = 1'b0;
                        r.unknown_op = 1'b1;
                    end
                endcase
            end
            OP_REGIMM:
            begin
                if (rtf == RT_BLTZ || rtf == RT_BLTZAL)
                begin
                    if (rs[31])
                        r.next_pc = btgt;
                end
                else if (rtf == RT_BGEZ || rtf == RT_BGEZAL)
                begin
                    if (!rs[31])
                        r.next_pc = btgt;
                end
                else
                    r.unknown_op = 1'b1;
                if (!r.unknown_op && rtf[4])
                begin
                    r.reg_write   = 1'b1;
                    r.dest_reg    = LINK_REG;
                    r.write_value = seq;
                end
            end
            OP_J:    r.next_pc = jtgt;
            OP_JAL:
            begin
                r.next_pc     = jtgt;
                r.reg_write   = 1'b1;
                r.dest_reg    = LINK_REG;
                r.write_value = seq;
            end
            OP_BEQ:  if (rs == rt) r.next_pc = btgt;
            OP_BNE:  if (rs != rt) r.next_pc = btgt;
            OP_BLEZ: if (rs[31] || rs == 32'h0) r.next_pc = btgt;
            OP_BGTZ: if (!rs[31] && rs != 32'h0) r.next_pc = btgt;
            OP_ADDI, OP_ADDIU, OP_SLTI, OP_SLTIU, OP_ANDI, OP_ORI, OP_XORI, OP_LUI:
            begin
                r.reg_write = 1'b1;
                r.dest_reg  = rtf;
                case (op)
                    OP_SLTI:  r.write_value = {31'h0, $signed(rs) < $signed(simm)};
                    OP_SLTIU: r.write_value = {31'h0, rs < simm};
                    OP_ANDI:  r.write_value = rs & imm;
                    OP_ORI:   r.write_value = rs | imm;
                    OP_XORI:  r.write_value = rs ^ imm;
                    OP_LUI:   r.write_value = imm << 16;
                    default:  r.write_value = rs + simm;
                endcase
            end
            OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU:
            begin
                r.reg_write   = 1'b1;
                r.dest_reg    = rtf;
                r.mem_read    = 1'b1;
                r.mem_address = rs + simm;
                case (op)
                    OP_LB:   r.load_kind = LK_SBYTE;
                    OP_LH:   r.load_kind = LK_SHALF;
                    OP_LBU:  r.load_kind = LK_UBYTE;
                    OP_LHU:  r.load_kind = LK_UHALF;
                    default: r.load_kind = LK_WORD;
                endcase
            end
            OP_SB, OP_SH, OP_SW:
            begin
                r.mem_write   = 1'b1;
                r.mem_address = rs + simm;
                lane          = r.mem_address[1:0];
                if (op == OP_SB)
                begin
                    r.store_data   = {24'h0, rt[7:0]} << (8 * lane);
                    r.byte_enables = 4'b0001 << lane;
                end
                else if (op == OP_SH)
                begin
                    r.store_data   = {16'h0, rt[15:0]} << (16 * lane[1]);
                    r.byte_enables = 4'b0011 << (2 * lane[1]);
                end
                else
                begin
                    r.store_data   = rt;
                    r.byte_enables = 4'hF;
                end
            end
            default: r.unknown_op = 1'b1;
        endcase
        if (!r.reg_write)
        begin
            r.dest_reg    = '0;
            r.write_value = '0;
        end
        return r;
    endfunction

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 5))
            0:       return 32'h0;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return $urandom_range(0, 40);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] rand_instr();
        logic [31:0] ins;
        logic [5:0]  ops[24];
        logic [5:0]  fns[27];
        ops = '{OP_SPECIAL, OP_REGIMM, OP_J, OP_JAL, OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ,
                OP_ADDI, OP_ADDIU, OP_SLTI, OP_SLTIU, OP_ANDI, OP_ORI, OP_XORI, OP_LUI,
                OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU, OP_SB, OP_SH, OP_SW};
        fns = '{FN_SLL, FN_SRL, FN_SRA, FN_SLLV, FN_SRLV, FN_SRAV, FN_JR, FN_JALR,
                FN_SYSCALL, FN_MFHI, FN_MTHI, FN_MFLO, FN_MTLO, FN_MULT, FN_MULTU,
                FN_DIV, FN_DIVU, FN_ADD, FN_ADDU, FN_SUB, FN_SUBU, FN_AND, FN_OR,
                FN_XOR, FN_NOR, FN_SLT, FN_SLTU};
        ins = $urandom;
        case ($urandom_range(0, 9))
            0:       ;
            1, 2, 3: ins[31:26] = ops[$urandom_range(0, 23)];
            default:
            begin
                ins[31:26] = OP_SPECIAL;
                ins[5:0]   = fns[$urandom_range(0, 26)];
            end
        endcase
        if (ins[31:26] == OP_REGIMM && $urandom_range(0, 3) != 0)
            ins[20:16] = {$urandom_range(0, 1) == 1, 3'b000, $urandom_range(0, 1) == 1};
        return ins;
    endfunction

    function automatic in_word_t make_word(logic [31:0] ins, logic [31:0] pc,
                                           logic [31:0] rs, logic [31:0] rt);
        in_word_t w;
        w.instr    = ins;
        w.pc       = pc;
        w.rs_value = rs;
        w.rt_value = rt;
        return w;
    endfunction

    task automatic send_word(in_word_t w, logic known, out_word_t res);
        out_word_t predicted;
        while (!quiet && src_gap == 0 && $urandom_range(0, 7) == 0)
            src_gap = $urandom_range(1, 5);
        while (src_gap > 0)
        begin
            src_valid <= 1'b0;
            @(posedge clk);
            src_gap--;
        end
        src_valid <= 1'b1;
        src_data  <= w;
        do
            @(posedge clk);
        while (src_stall);
        predicted = execute(w);
        pending_q.push_back(known ? res : predicted);
        if (known && res != predicted)
            $display("%0t table row disagrees with predictor for %h", $time, w.instr);
    endtask

    task automatic drain();
        src_valid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((src_valid && !src_stall) || (dst_valid && !dst_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles > 2000)
            begin
                $display("mips_decode_execute_unit verification failed");
                $finish;
            end
        end
    end

    always @(posedge clk)
    begin
        out_word_t want;
        if (rst_n && dst_valid && !dst_stall)
        begin
            if (pending_q.size() == 0)
            begin
                $display("%0t unexpected word %h", $time, dst_data);
                errors++;
            end
            else
            begin
                want = pending_q.pop_front();
                if (want.next_pc != dst_data.next_pc
                    || want.dest_reg != dst_data.dest_reg
                    || want.reg_write != dst_data.reg_write
                    || want.write_value != dst_data.write_value
                    || want.mem_read != dst_data.mem_read
                    || want.mem_write != dst_data.mem_write
                    || want.mem_address != dst_data.mem_address
                    || want.store_data != dst_data.store_data
                    || want.byte_enables != dst_data.byte_enables
                    || want.load_kind != dst_data.load_kind
                    || want.halt != dst_data.halt
                    || want.unknown_op != dst_data.unknown_op)
                begin
                    $display("%0t mismatch expected %h actual %h", $time, want, dst_data);
                    errors++;
                end
            end
        end
        if (!rst_n || quiet)
            dst_stall <= 1'b0;
        else if (dst_hold > 0)
        begin
            dst_stall <= 1'b1;
            dst_hold  <= dst_hold - 1;
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            dst_stall <= 1'b1;
            dst_hold  <= $urandom_range(0, 4);
        end
        else
            dst_stall <= 1'b0;
    end

    initial
    begin
        row_t      rows[$];
        row_t      rw;
        out_word_t r;
        rst_n       = 1'b0;
        src_valid   = 1'b0;
        src_data    = '0;
        dst_stall   = 1'b0;
        errors      = 0;
        idle_cycles = 0;
        quiet       = 1'b0;
        src_gap     = 0;
        dst_hold    = 0;
        hi_q        = '0;
        lo_q        = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        r = '0; r.next_pc = 32'h4; r.reg_write = 1'b1; r.dest_reg = 5'd3;
        rw.word = make_word({OP_SPECIAL, 10'h0, 5'd3, 5'd0, FN_MFHI}, 32'h0, '0, '0);
        rw.known = 1'b1; rw.result = r; rows.push_back(rw);
        r = '0; r.next_pc = 32'h0; r.unknown_op = 1'b1;
        rw.word = make_word({6'h3F, 26'h3FF_FFFF}, 32'hFFFF_FFFC, '1, '1);
        rw.known = 1'b1; rw.result = r; rows.push_back(rw);
        r = '0; r.next_pc = 32'h104; r.unknown_op = 1'b1;
        rw.word = make_word({OP_SPECIAL, 20'h0, 6'h3F}, 32'h100, '1, '1);
        rw.known = 1'b1; rw.result = r; rows.push_back(rw);
        r = '0; r.next_pc = 32'h8; r.halt = 1'b1;
        rw.word = make_word({OP_SPECIAL, 20'h0, FN_SYSCALL}, 32'h4, '1, '1);
        rw.known = 1'b1; rw.result = r; rows.push_back(rw);
        r = '0; r.next_pc = 32'h4; r.reg_write = 1'b1; r.dest_reg = 5'd1;
        r.write_value = 32'h0;
        rw.word = make_word({OP_SPECIAL, 5'd0, 5'd0, 5'd1, 5'd0, FN_ADD}, 32'h0,
                            32'hFFFF_FFFF, 32'h1);
        rw.known = 1'b1; rw.result = r; rows.push_back(rw);
        rw.known = 1'b0;
        rw.word = make_word({OP_SPECIAL, 20'h0, FN_DIV}, 32'h0, 32'h1234, 32'h0);
        rows.push_back(rw);
        rw.word = make_word({OP_SPECIAL, 5'd0, 5'd0, 5'd2, 5'd0, FN_MFLO}, 0, 0, 0);
        rows.push_back(rw);
        rw.word = make_word({OP_SPECIAL, 5'd0, 5'd0, 5'd2, 5'd0, FN_MFHI}, 0, 0, 0);
        rows.push_back(rw);
        rw.word = make_word({OP_SPECIAL, 20'h0, FN_DIVU}, 32'h0, 32'h55, 32'h0);
        rows.push_back(rw);
        rw.word = make_word({OP_SPECIAL, 20'h0, FN_DIV}, 0, 32'h8000_0000, 32'hFFFF_FFFF);
        rows.push_back(rw);
        rw.word = make_word({OP_SPECIAL, 5'd0, 5'd0, 5'd4, 5'd0, FN_MFLO}, 0, 0, 0);
        rows.push_back(rw);
        rw.word = make_word({OP_SPECIAL, 20'h0, FN_MULT}, 0, 32'h8000_0000, 32'hFFFF_FFFF);
        rows.push_back(rw);
        rw.word = make_word({OP_SPECIAL, 20'h0, FN_MULTU}, 0, '1, '1);
        rows.push_back(rw);
        rw.word = make_word({OP_SPECIAL, 5'd0, 5'd0, 5'd5, 5'd0, FN_MFHI}, 0, 0, 0);
        rows.push_back(rw);
        rw.word = make_word({OP_REGIMM, 5'd1, RT_BLTZAL, 16'h8000}, 32'h1000, '1, 0);
        rows.push_back(rw);
        rw.word = make_word({OP_REGIMM, 5'd1, RT_BGEZAL, 16'h7FFF}, 32'h1000, '1, 0);
        rows.push_back(rw);
        rw.word = make_word({OP_SH, 5'd1, 5'd2, 16'hFFFF}, 0, 32'h0, 32'hABCD);
        rows.push_back(rw);
        rw.word = make_word({OP_SW, 5'd1, 5'd2, 16'h0001}, 0, 32'h2, 32'h1234_5678);
        rows.push_back(rw);
        rw.word = make_word({OP_SB, 5'd1, 5'd2, 16'h0003}, 0, 32'h0, 32'hFF);
        rows.push_back(rw);
        rw.word = make_word({OP_JAL, 26'h3FF_FFFF}, 32'hF000_0000, 0, 0);
        rows.push_back(rw);
        rw.word = make_word({OP_LUI, 5'd0, 5'd0, 16'hFFFF}, 0, 0, 0);
        rows.push_back(rw);
        rw.word = make_word({OP_SLTIU, 5'd1, 5'd7, 16'h8000}, 0, 32'h7FFF_FFFF, 0);
        rows.push_back(rw);
        rw.word = make_word({OP_LH, 5'd1, 5'd7, 16'hFFFF}, 0, 32'h0, 0);
        rows.push_back(rw);

        foreach (rows[i])
            send_word(rows[i].word, rows[i].known, rows[i].result);
        drain();

        for (int n = 0; n < 650; n++)
        begin
            if (n == 300)
                drain();
            if (n == 550)
                quiet = 1'b1;
            send_word(make_word(rand_instr(), rand_value(), rand_value(), rand_value()),
                      1'b0, '0);
        end
        drain();
        repeat (40) @(posedge clk);
        if (errors == 0 && pending_q.size() == 0)
            $display("mips_decode_execute_unit verification clean");
        else
            $display("mips_decode_execute_unit verification failed");
        $finish;
    end
endmodule
`default_nettype wire

[sim.f]
sv/mde_pkg.sv
sv/mde_ctrl.sv
sv/mde_datapath.sv
sv/mips_decode_execute_unit.sv
bench/mips_decode_execute_unit_tb.sv
